### sv/firdf_pkg.sv
// ----------------------------------------------------------------------------
// firdf_pkg
// shared widths, types and saturation limits of the direct-form fir filter
// ----------------------------------------------------------------------------
package firdf_pkg;

   localparam int TAP_COUNT  = 8;              // taps in use, 2 .. 8
   localparam int COEF_REGS  = 8;              // coefficient registers on the bus
   localparam int LINE_DEPTH = TAP_COUNT - 1;  // past samples kept
   localparam int SAMPLE_W   = 16;
   localparam int PROD_W     = 2 * SAMPLE_W;
   localparam int ACC_W      = 40;
   localparam int FRAC_W     = 15;
   localparam int CSR_AW     = 5;
   localparam int CSR_DW     = 32;
   localparam int REG_IDX_W  = $clog2(COEF_REGS);

   typedef logic signed [SAMPLE_W-1:0]   sample_type;
   typedef logic signed [PROD_W-1:0]     product_type;
   typedef logic signed [ACC_W-1:0]      acc_type;
   typedef sample_type  [TAP_COUNT-1:0]  window_type;
   typedef sample_type  [COEF_REGS-1:0]  coef_array_type;
   typedef product_type [TAP_COUNT-1:0]  prod_array_type;

   localparam sample_type SAT_HI     = 16'sh7FFF;
   localparam sample_type SAT_LO     = 16'sh8000;
   localparam acc_type    ROUND_BIAS = acc_type'(1) <<< (FRAC_W - 1);

endpackage

### sv/firdf_csr.sv
// ----------------------------------------------------------------------------
// firdf_csr
// apb-style coefficient register file
// ----------------------------------------------------------------------------
module firdf_csr import firdf_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_psel,
   input  logic                 csr_penable,
   input  logic                 csr_pwrite,
   input  logic [CSR_AW-1:0]    csr_paddr,
   input  logic [CSR_DW-1:0]    csr_pwdata,
   output logic [CSR_DW-1:0]    csr_prdata,
   output logic                 csr_pready,
   output coef_array_type       coef
);

   coef_array_type         coef_ff, coef_in;
   logic [REG_IDX_W-1:0]   idx;
   logic                   wr_en;

   assign idx        = csr_paddr[REG_IDX_W+1:2];
   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      coef_in = coef_ff;
      if (wr_en) begin
         coef_in[idx] = csr_pwdata[SAMPLE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff <= '0;
      end else begin
         coef_ff <= coef_in;
      end
   end

   assign csr_prdata = CSR_DW'($signed(coef_ff[idx]));
   assign coef       = coef_ff;

endmodule

### sv/firdf_taps.sv
// ----------------------------------------------------------------------------
// firdf_taps
// delay line and input register holding the window of one item
// ----------------------------------------------------------------------------
module firdf_taps import firdf_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   input  logic        stage_en,
   input  sample_type  sample_in,
   output logic        win_valid,
   output window_type  win
);

   sample_type [LINE_DEPTH-1:0] line_ff, line_in;
   window_type                  win_ff, win_in;
   logic                        valid_ff;
   logic                        take;

   assign take = in_valid & stage_en;

   always_comb begin
      win_in     = win_ff;
      line_in    = line_ff;
      if (take) begin
         win_in[0] = sample_in;
         for (int k = 1; k < TAP_COUNT; k++) begin
            win_in[k] = line_ff[k-1];
         end
         for (int k = 1; k < LINE_DEPTH; k++) begin
            line_in[k] = line_ff[k-1];
         end
         line_in[0] = sample_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         line_ff  <= '0;
      end else begin
         line_ff <= line_in;
         if (stage_en) begin
            valid_ff <= in_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      win_ff <= win_in;
   end

   assign win_valid = valid_ff;
   assign win       = win_ff;

endmodule

### sv/firdf_mult.sv
// ----------------------------------------------------------------------------
// firdf_mult
// one multiplier per tap, products registered
// ----------------------------------------------------------------------------
module firdf_mult import firdf_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            in_valid,
   input  logic            stage_en,
   input  window_type      win,
   input  coef_array_type  coef,
   output logic            prod_valid,
   output prod_array_type  prod
);

   prod_array_type prod_ff, prod_in;
   logic           valid_ff;

   always_comb begin
      for (int k = 0; k < TAP_COUNT; k++) begin
         prod_in[k] = product_type'($signed(win[k])) * product_type'($signed(coef[k]));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (stage_en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en && in_valid) begin
         prod_ff <= prod_in;
      end
   end

   assign prod_valid = valid_ff;
   assign prod       = prod_ff;

endmodule

### sv/firdf_acc.sv
// ----------------------------------------------------------------------------
// firdf_acc
// exact sum of the tap products into the wide accumulator
// ----------------------------------------------------------------------------
module firdf_acc import firdf_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            in_valid,
   input  logic            stage_en,
   input  prod_array_type  prod,
   output logic            acc_valid,
   output acc_type         acc
);

   acc_type acc_ff, acc_in;
   logic    valid_ff;

   always_comb begin
      acc_in = '0;
      for (int k = 0; k < TAP_COUNT; k++) begin
         acc_in = acc_in + acc_type'($signed(prod[k]));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (stage_en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en && in_valid) begin
         acc_ff <= acc_in;
      end
   end

   assign acc_valid = valid_ff;
   assign acc       = acc_ff;

endmodule

### sv/firdf_round.sv
// ----------------------------------------------------------------------------
// firdf_round
// round half up to q1.15, saturate, result register
// ----------------------------------------------------------------------------
module firdf_round import firdf_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   input  logic        stage_en,
   input  acc_type     acc,
   output logic        out_valid,
   output sample_type  sample_out
);

   acc_type    rnd;
   sample_type y_ff, y_in;
   logic       valid_ff;

   assign rnd = (acc + ROUND_BIAS) >>> FRAC_W;

   always_comb begin
      if (rnd > acc_type'(SAT_HI)) begin
         y_in = SAT_HI;
      end else if (rnd < acc_type'(SAT_LO)) begin
         y_in = SAT_LO;
      end else begin
         y_in = rnd[SAMPLE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (stage_en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en && in_valid) begin
         y_ff <= y_in;
      end
   end

   assign out_valid  = valid_ff;
   assign sample_out = y_ff;

endmodule

### sv/fir_filter_direct_form_unit.sv
// ----------------------------------------------------------------------------
// fir_filter_direct_form_unit
// direct-form fir filter, q1.15 samples and coefficients, one item per cycle
// ----------------------------------------------------------------------------
//
//   channel   direction   ports          contents
//   req       in          req_t*         one new sample per item
//   rsp       out         rsp_t*         one filtered sample per item
//   csr       in/out      csr_*          coef_0 .. coef_7 at byte 4*k
//
// one item per cycle sustained while rsp_tready stays high
// stages: window register, tap multipliers, accumulator, round and saturate
// each stage holds its item until the next one frees up, so bubbles are
// squeezed out and req_tready stays high while any stage is empty
// synchronous active-high reset clears the delay line, the coefficients and
// all stage valid bits
// ----------------------------------------------------------------------------
module fir_filter_direct_form_unit import firdf_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   // input item
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [15:0]          req_tdata,    // [15:0] sample_in
   // result item
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [15:0]          rsp_tdata,    // [15:0] sample_out
   // coefficient registers
   input  logic                 csr_psel,
   input  logic                 csr_penable,
   input  logic                 csr_pwrite,
   input  logic [CSR_AW-1:0]    csr_paddr,
   input  logic [CSR_DW-1:0]    csr_pwdata,
   output logic [CSR_DW-1:0]    csr_prdata,
   output logic                 csr_pready
);

   coef_array_type coef;
   window_type     win;
   prod_array_type prod;
   acc_type        acc;
   sample_type     y;

   logic win_valid, prod_valid, acc_valid, out_valid;
   logic en_taps, en_mult, en_acc, en_out;

   // a stage may load when it is empty or its content moves on this cycle
   assign en_out  = ~out_valid  | rsp_tready;
   assign en_acc  = ~acc_valid  | en_out;
   assign en_mult = ~prod_valid | en_acc;
   assign en_taps = ~win_valid  | en_mult;

   assign req_tready = en_taps;

   // coefficient registers
   firdf_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .coef        (coef)
   );

   // delay line shifts only on an accepted item
   firdf_taps u_taps (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .stage_en  (en_taps),
      .sample_in (sample_type'(req_tdata)),
      .win_valid (win_valid),
      .win       (win)
   );

   // products are exact q2.30
   firdf_mult u_mult (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (win_valid),
      .stage_en   (en_mult),
      .win        (win),
      .coef       (coef),
      .prod_valid (prod_valid),
      .prod       (prod)
   );

   // wide sum cannot overflow
   firdf_acc u_acc (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (prod_valid),
      .stage_en  (en_acc),
      .prod      (prod),
      .acc_valid (acc_valid),
      .acc       (acc)
   );

   // result register doubles as the output holding stage
   firdf_round u_round (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (acc_valid),
      .stage_en   (en_out),
      .acc        (acc),
      .out_valid  (out_valid),
      .sample_out (y)
   );

   assign rsp_tvalid = out_valid;
   assign rsp_tdata  = y;

`ifndef SYNTHESIS
   // an accepted item lands in the window register
   a_take_loads: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> win_valid)
      else $error("accepted item not captured");

   // a stalled window stage keeps its item
   a_win_hold: assert property (@(posedge clock) disable iff (reset)
      win_valid && !en_mult |=> win_valid && $stable(win))
      else $error("window item lost under stall");

   // a stalled accumulator keeps its item
   a_acc_hold: assert property (@(posedge clock) disable iff (reset)
      acc_valid && !en_out |=> acc_valid && $stable(acc))
      else $error("accumulator item lost under stall");

   // no result right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && !win_valid)
      else $error("pipeline not empty after reset");
`endif

endmodule

### tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the direct-form fir filter unit
// drives samples over the req stream, loads coefficients over the csr port,
// predicts every filtered sample and compares it with what rsp delivers
// ----------------------------------------------------------------------------
module tb import firdf_pkg::*; ();

   // idle cycles allowed with nothing moving before the run is declared stuck
   localparam int WATCHDOG_LIMIT   = 2000;
   // pipeline is four stages deep, give it a little more before a csr write
   localparam int SETTLE_CYCLES    = 8;
   localparam int HOLD_OFF_CYCLES  = 60;
   localparam int RANDOM_PHASES    = 8;
   localparam int ITEMS_PER_PHASE  = 228;
   localparam int N_DIRECTED       = 35;
   localparam int MAX_REPORTS      = 40;

   typedef enum logic [1:0] {ROW_COEF, ROW_SAMPLE, ROW_KNOWN} row_kind_type;

   typedef enum logic [1:0] {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   typedef enum logic [2:0] {
      COEF_RANDOM_SMALL,
      COEF_RANDOM_FULL,
      COEF_ALL_MAX,
      COEF_ALL_MIN,
      COEF_ALTERNATE,
      COEF_ONE_TAP
   } coef_style_type;

   // one directed step: a coefficient load, or a sample with or without a
   // result that is typed in here
   typedef struct packed {
      row_kind_type            kind;
      logic [REG_IDX_W-1:0]    idx;
      sample_type              value;
      sample_type              want;
   } stim_row_type;

   // ------------------------------------------------------------------------
   // signals to the unit, all known from time zero
   // ------------------------------------------------------------------------
   logic                clock;
   logic                reset        = 1'b1;
   logic                req_tvalid   = 1'b0;
   logic                req_tready;
   logic [15:0]         req_tdata    = '0;     // [15:0] sample_in
   logic                rsp_tvalid;
   logic                rsp_tready   = 1'b0;
   logic [15:0]         rsp_tdata;             // [15:0] sample_out
   logic                csr_psel     = 1'b0;
   logic                csr_penable  = 1'b0;
   logic                csr_pwrite   = 1'b0;
   logic [CSR_AW-1:0]   csr_paddr    = '0;
   logic [CSR_DW-1:0]   csr_pwdata   = '0;
   logic [CSR_DW-1:0]   csr_prdata;
   logic                csr_pready;

   fir_filter_direct_form_unit u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // filter state as the bench sees it
   // ------------------------------------------------------------------------
   sample_type  tap_coef [COEF_REGS] = '{default: '0};
   sample_type  past     [LINE_DEPTH] = '{default: '0};
   sample_type  expected_out [$];

   int          send_idle_pct    = 0;   // chance of a gap after each item
   int          rsp_stall_pct    = 0;   // chance of rsp_tready low per cycle
   bit          hold_off_req     = 1'b0;
   int          mismatch_count   = 0;
   int          samples_sent     = 0;
   int          results_checked  = 0;
   int          coef_settings    = 0;
   int          quiet_cycles     = 0;

   // directed steps, written out so the easy answers can be typed in
   stim_row_type directed_rows [N_DIRECTED] = '{
      // coefficients are all zero after reset, so is every output
      '{ROW_KNOWN,  3'd0, 16'h7FFF, 16'h0000},
      '{ROW_KNOWN,  3'd0, 16'h8000, 16'h0000},
      // single tap near +1.0: largest products of either sign
      '{ROW_COEF,   3'd0, 16'h7FFF, 16'h0000},
      '{ROW_KNOWN,  3'd0, 16'h7FFF, 16'h7FFE},
      '{ROW_KNOWN,  3'd0, 16'h8000, 16'h8001},
      '{ROW_KNOWN,  3'd0, 16'h0001, 16'h0001},
      '{ROW_KNOWN,  3'd0, 16'hFFFF, 16'hFFFF},
      '{ROW_KNOWN,  3'd0, 16'h0000, 16'h0000},
      // half gain: odd samples land exactly on a rounding tie
      '{ROW_COEF,   3'd0, 16'h4000, 16'h0000},
      '{ROW_KNOWN,  3'd0, 16'h0001, 16'h0001},
      '{ROW_KNOWN,  3'd0, 16'hFFFF, 16'h0000},
      '{ROW_KNOWN,  3'd0, 16'h0003, 16'h0002},
      '{ROW_KNOWN,  3'd0, 16'hFFFD, 16'hFFFF},
      // -1.0 times -1.0 is +1.0 and must clip to the top
      '{ROW_COEF,   3'd0, 16'h8000, 16'h0000},
      '{ROW_KNOWN,  3'd0, 16'h8000, 16'h7FFF},
      '{ROW_KNOWN,  3'd0, 16'h7FFF, 16'h8001},
      '{ROW_KNOWN,  3'd0, 16'h0001, 16'hFFFF},
      // every tap at full gain, the sum runs far out of range on the high side
      '{ROW_COEF,   3'd1, 16'h7FFF, 16'h0000},
      '{ROW_COEF,   3'd2, 16'h7FFF, 16'h0000},
      '{ROW_COEF,   3'd3, 16'h7FFF, 16'h0000},
      '{ROW_COEF,   3'd4, 16'h7FFF, 16'h0000},
      '{ROW_COEF,   3'd5, 16'h7FFF, 16'h0000},
      '{ROW_COEF,   3'd6, 16'h7FFF, 16'h0000},
      '{ROW_COEF,   3'd7, 16'h7FFF, 16'h0000},
      '{ROW_COEF,   3'd0, 16'h7FFF, 16'h0000},
      '{ROW_SAMPLE, 3'd0, 16'h7FFF, 16'h0000},
      '{ROW_SAMPLE, 3'd0, 16'h7FFF, 16'h0000},
      '{ROW_SAMPLE, 3'd0, 16'h7FFF, 16'h0000},
      '{ROW_SAMPLE, 3'd0, 16'h7FFF, 16'h0000},
      '{ROW_SAMPLE, 3'd0, 16'h8000, 16'h0000},
      '{ROW_SAMPLE, 3'd0, 16'h8000, 16'h0000},
      '{ROW_SAMPLE, 3'd0, 16'h8000, 16'h0000},
      '{ROW_SAMPLE, 3'd0, 16'h8000, 16'h0000},
      // alternating bit patterns through the whole delay line
      '{ROW_SAMPLE, 3'd0, 16'h5555, 16'h0000},
      '{ROW_SAMPLE, 3'd0, 16'hAAAA, 16'h0000}
   };

   // ------------------------------------------------------------------------
   // predictor: one sample in, one filtered sample out, delay line advances
   // ------------------------------------------------------------------------
   function automatic sample_type filter_step(input sample_type x);
      longint sum;
      longint rounded;
      int     k;
      // exact sum of all tap products, no width limit on the bench side
      sum = longint'(tap_coef[0]) * longint'(x);
      for (k = 1; k < TAP_COUNT; k++)
         sum += longint'(tap_coef[k]) * longint'(past[k-1]);
      // shift the delay line, newest sample in front
      for (k = TAP_COUNT - 2; k > 0; k--)
         past[k] = past[k-1];
      past[0] = x;
      // round half up to q1.15, then clip
      rounded = (sum + longint'(ROUND_BIAS)) >>> FRAC_W;
      if (rounded > longint'(SAT_HI))
         return SAT_HI;
      if (rounded < longint'(SAT_LO))
         return SAT_LO;
      return sample_type'(rounded);
   endfunction

   task automatic report_mismatch(input string what, input logic [15:0] got,
                                  input logic [15:0] want);
      if (mismatch_count < MAX_REPORTS)
         $display("[%0t] mismatch: %s, got %0d, expected %0d", $realtime, what,
                  $signed(got), $signed(want));
      mismatch_count++;
   endtask

   // ------------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------------
   // offer one sample and hold it until taken; the prediction is made at the
   // edge of acceptance, a typed-in answer replaces it where given
   task automatic offer_sample(input sample_type s, input bit typed,
                               input sample_type want);
      sample_type predicted;
      req_tvalid <= 1'b1;
      req_tdata  <= s;
      do @(posedge clock); while (!req_tready);
      predicted = filter_step(s);
      expected_out.push_back(typed ? want : predicted);
      samples_sent++;
   endtask

   // random gap after an item, geometric length so gaps land anywhere
   task automatic sender_gap();
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
   endtask

   // sender goes quiet until every expected item is back and the pipe is empty
   task automatic drain_pipeline();
      req_tvalid <= 1'b0;
      while (expected_out.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // apb write: setup phase, access phase held until csr_pready, then the bus is released
   task automatic csr_write(input logic [REG_IDX_W-1:0] idx, input sample_type value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_AW'(idx) << 2;
      csr_pwdata  <= CSR_DW'($unsigned(value));
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      tap_coef[idx] = value;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_idle(input idle_mode_type mode);
      send_idle_pct = (mode == IDLE_SENDER) ? 87 : (mode == IDLE_BOTH) ? 12 : 0;
      rsp_stall_pct = (mode == IDLE_RECEIVER) ? 87 : (mode == IDLE_BOTH) ? 12 : 0;
   endtask

   function automatic sample_type pick_coef(input coef_style_type style, input int k,
                                            input int one_tap);
      case (style)
         COEF_RANDOM_SMALL: return sample_type'($urandom_range(8191) - 4096);
         COEF_RANDOM_FULL:  return sample_type'($urandom());
         COEF_ALL_MAX:      return SAT_HI;
         COEF_ALL_MIN:      return SAT_LO;
         COEF_ALTERNATE:    return (k % 2 == 0) ? SAT_HI : SAT_LO;
         default:           return (k == one_tap) ? sample_type'($urandom()) : '0;
      endcase
   endfunction

   // mostly random samples, with the extremes and values near zero mixed in
   function automatic sample_type pick_sample();
      int r;
      r = $urandom_range(99);
      if (r < 4)
         return SAT_HI;
      if (r < 8)
         return SAT_LO;
      if (r < 10)
         return '0;
      if (r < 12)
         return 16'sh0001;
      if (r < 14)
         return -16'sh0001;
      if (r < 40)
         return sample_type'($urandom_range(1023) - 512);
      return sample_type'($urandom());
   endfunction

   // ------------------------------------------------------------------------
   // receiver: random stalls, plus one long hold-off on request
   // ------------------------------------------------------------------------
   initial begin : receiver
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            rsp_tready <= 1'b0;
            // counted here so the sender keeps pushing and the unit backs up
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end else begin
            rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   // ------------------------------------------------------------------------
   // result checker, sampled at the edge with pre-edge values
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : check_results
      sample_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_out.size() == 0) begin
            report_mismatch("result with nothing expected", rsp_tdata, 16'h0000);
         end else begin
            want = expected_out.pop_front();
            if (rsp_tdata !== want)
               report_mismatch("sample_out", rsp_tdata, want);
            results_checked++;
         end
      end
   end

   // ------------------------------------------------------------------------
   // watchdog: too long with no item, result or csr access means stuck
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_psel) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: nothing moved for %0d cycles, %0d items still expected",
                  quiet_cycles, expected_out.size());
         $display("FAILURE");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ------------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------------
   initial begin : stimulus
      int             ph;
      int             n;
      int             k;
      int             one_tap;
      coef_style_type style;

      rsp_stall_pct = 0;
      send_idle_pct = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part, back to back with a ready receiver
      for (n = 0; n < N_DIRECTED; n++) begin
         case (directed_rows[n].kind)
            ROW_COEF: begin
               // coefficients only change with the pipeline empty
               drain_pipeline();
               csr_write(directed_rows[n].idx, directed_rows[n].value);
               coef_settings++;
            end
            ROW_KNOWN:  offer_sample(directed_rows[n].value, 1'b1, directed_rows[n].want);
            default:    offer_sample(directed_rows[n].value, 1'b0, '0);
         endcase
      end

      // random phases, each with fresh coefficients and its own idle pattern
      for (ph = 0; ph < RANDOM_PHASES; ph++) begin
         drain_pipeline();
         style   = coef_style_type'(ph % 6);
         one_tap = $urandom_range(COEF_REGS - 1);
         for (k = 0; k < COEF_REGS; k++)
            csr_write(k[REG_IDX_W-1:0], pick_coef(style, k, one_tap));
         coef_settings++;
         set_idle(idle_mode_type'(ph % 4));
         for (n = 0; n < ITEMS_PER_PHASE; n++) begin
            // long receiver hold-off while the sender streams without gaps
            if (ph == 0 && n == 20)
               hold_off_req = 1'b1;
            offer_sample(pick_sample(), 1'b0, '0);
            sender_gap();
         end
      end

      // everything offered: wait out the tail, stray results still get caught
      set_idle(IDLE_NONE);
      drain_pipeline();

      $display("run covered %0d samples under %0d coefficient settings,", samples_sent,
               coef_settings);
      $display("with %0d filtered samples checked and %0d mismatches", results_checked,
               mismatch_count);
      if (mismatch_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
